### rtl/wcta_pkg.sv
// ----------------------------------------------------------------------------
// wcta_pkg
// Shared types and codes of the wall column texel address generator.
// ----------------------------------------------------------------------------
package wcta_pkg;

	localparam logic FUNC_SETUP = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	localparam logic [2:0] REG_TEX_WIDTH       = 3'd0;
	localparam logic [2:0] REG_TEX_HEIGHT      = 3'd1;
	localparam logic [2:0] REG_SCREEN_HEIGHT   = 3'd2;
	localparam logic [2:0] REG_ROW_PITCH       = 3'd3;
	localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd4;

	localparam logic [10:0] RST_TEX_WIDTH       = 11'd64;
	localparam logic [10:0] RST_TEX_HEIGHT      = 11'd64;
	localparam logic [11:0] RST_SCREEN_HEIGHT   = 12'd480;
	localparam logic [15:0] RST_ROW_PITCH       = 16'd256;
	localparam logic [3:0]  RST_BYTES_PER_PIXEL = 4'd4;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [10:0] tex_width;
		logic [10:0] tex_height;
		logic [11:0] screen_height;
		logic [15:0] row_pitch;
		logic [3:0]  bytes_per_pixel;
	} cfg_t;

	typedef struct packed {
		logic               func;
		logic               mirror;
		logic [23:0]        base;
		logic [23:0]        hit_dist;
		logic signed [17:0] dir;
		logic [15:0]        wall_height;
		logic [11:0]        draw_start;
		logic [11:0]        draw_end;
		logic [11:0]        column_x;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_COL,
		ST_DIV,
		ST_START,
		ST_SMOD,
		ST_FIX_ACC,
		ST_FIX_COL,
		ST_STEP_MOD
	} state_t;

endpackage

### rtl/wcta_front.sv
// ----------------------------------------------------------------------------
// wcta_front
// Classifies an incoming beat: picks the hit axis, facing and wall height.
// ----------------------------------------------------------------------------
module wcta_front (
	input  logic               func,
	input  logic               side,
	input  logic [23:0]        pos_x,
	input  logic [23:0]        pos_y,
	input  logic [23:0]        perp_dist,
	input  logic signed [17:0] ray_dir_x,
	input  logic signed [17:0] ray_dir_y,
	input  logic [15:0]        wall_height,
	input  logic [11:0]        draw_start,
	input  logic [11:0]        draw_end,
	input  logic [11:0]        column_x,
	output wcta_pkg::item_t    item
);

	always_comb begin
		item.func        = func;
		item.mirror      = side ? ray_dir_y[17] : (!ray_dir_x[17] && (ray_dir_x != 18'sd0));
		item.base        = side ? pos_x : pos_y;
		item.dir         = side ? ray_dir_x : ray_dir_y;
		item.hit_dist    = perp_dist;
		item.wall_height = (wall_height == 16'd0) ? 16'd1 : wall_height;
		item.draw_start  = draw_start;
		item.draw_end    = draw_end;
		item.column_x    = column_x;
	end

endmodule

### rtl/wcta_queue.sv
// ----------------------------------------------------------------------------
// wcta_queue
// Short queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module wcta_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  wcta_pkg::item_t wr_item,
	output logic            full,
	input  logic            rd_en,
	output wcta_pkg::item_t rd_item,
	output logic            rd_valid
);

	localparam int AW = (wcta_pkg::QDEPTH > 1) ? $clog2(wcta_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(wcta_pkg::QDEPTH + 1);

	wcta_pkg::item_t mem_q [wcta_pkg::QDEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(wcta_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(wcta_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(wcta_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

### rtl/wcta_div.sv
// ----------------------------------------------------------------------------
// wcta_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module wcta_div #(
	parameter int DW = 43
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q, dvs_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   trial;
	logic [DW-1:0] rem_shift;

	assign rem_shift = {rem_q[DW-2:0], dvd_q[DW-1]};
	assign trial     = {rem_q, dvd_q[DW-1]} - {1'b0, dvs_q};
	assign busy      = busy_q;
	assign done      = done_q;
	assign quo       = dvd_q;
	assign rem       = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift;
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
			end
		end
	end

endmodule

### rtl/wcta_back.sv
// ----------------------------------------------------------------------------
// wcta_back
// Executes queued beats: column setup sequence and per-pixel texel offsets.
// ----------------------------------------------------------------------------
module wcta_back #(
	parameter int FRAC_BITS   = 16,
	parameter int TEX_DIM_MAX = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  wcta_pkg::cfg_t  cfg,
	input  wcta_pkg::item_t head,
	input  logic            head_valid,
	output logic            head_pop,
	input  logic            pop,
	output logic            empty,
	output logic [11:0]     out_column,
	output logic [11:0]     out_row,
	output logic [25:0]     texel_offset,
	output logic            last
);

	localparam int F  = FRAC_BITS;
	localparam int WW = $clog2(TEX_DIM_MAX + 1);
	localparam int RW = $clog2(TEX_DIM_MAX);
	localparam int SW = WW + F;
	localparam int DW = SW + 16;
	localparam int FW = 2 * F;
	localparam int XW = FW + 43;
	localparam int OW = (RW + 17 > 26) ? RW + 17 : 26;

	wcta_pkg::state_t state_q, state_d;

	logic [WW-1:0] w, h;
	logic [SW-1:0] wrap;

	logic [RW-1:0] col_q, colm_q;
	logic [WW-1:0] colw_q;
	logic [SW-1:0] step_q, acc_q;
	logic [11:0]   cur_row_q, end_row_q, cur_col_q;
	logic          active_q;
	logic [FW-1:0] frac_q;

	logic          out_valid_q, out_last_q;
	logic [11:0]   out_col_q, out_row_q;
	logic [25:0]   out_off_q;

	logic          div_start, div_busy, div_done;
	logic [DW-1:0] div_dvd, div_dvs, div_quo, div_rem;

	logic          emit, frac_ld, col_ld, col_rem_ld, step_ld;
	logic          acc_fast_ld, acc_rem_ld, acc_clr, fin_ld;

	logic [RW-1:0]        row;
	logic [RW+15:0]       row_bytes;
	logic [RW+3:0]        col_bytes;
	logic [OW-1:0]        off_full;
	logic                 acc_ok, col_ok, step_small, pix_last, out_free, tall;
	logic [SW:0]          step_sum;
	logic [SW-1:0]        acc_next;
	logic [12:0]          row_inc;
	logic signed [42:0]   prod;
	logic [XW-1:0]        frac_sum;
	logic [FW+WW-1:0]     col_prod;
	logic [WW-1:0]        tx, tx_c, tx_m;
	logic [15:0]          wh_excess;
	logic [DW-1:0]        start_prod;

	always_comb begin
		if (cfg.tex_width == 11'd0) begin
			w = WW'(1);
		end else if (32'(cfg.tex_width) > TEX_DIM_MAX) begin
			w = WW'(TEX_DIM_MAX);
		end else begin
			w = WW'(cfg.tex_width);
		end
		if (cfg.tex_height == 11'd0) begin
			h = WW'(1);
		end else if (32'(cfg.tex_height) > TEX_DIM_MAX) begin
			h = WW'(TEX_DIM_MAX);
		end else begin
			h = WW'(cfg.tex_height);
		end
	end

	assign wrap = {h, {F{1'b0}}};

	assign row        = acc_q[F+RW-1:F];
	assign row_bytes  = row * cfg.row_pitch;
	assign col_bytes  = colm_q * cfg.bytes_per_pixel;
	assign off_full   = OW'(row_bytes) + OW'(col_bytes);
	assign acc_ok     = acc_q < wrap;
	assign col_ok     = colw_q == w;
	assign step_small = step_q <= wrap;
	assign step_sum   = {1'b0, acc_q} + {1'b0, step_q};
	assign acc_next   = (step_sum >= {1'b0, wrap}) ? SW'(step_sum - {1'b0, wrap})
	                                               : step_sum[SW-1:0];
	assign row_inc    = {1'b0, cur_row_q} + 13'd1;
	assign pix_last   = row_inc >= {1'b0, end_row_q};
	assign out_free   = !out_valid_q || pop;

	assign prod     = $signed({1'b0, head.hit_dist}) * head.dir;
	assign frac_sum = XW'({head.base, {F{1'b0}}}) + {{(XW-43){prod[42]}}, prod};
	assign col_prod = frac_q * w;
	assign tx       = col_prod[FW+WW-1:FW];
	assign tx_c     = (tx >= w) ? w - 1'b1 : tx;
	assign tx_m     = head.mirror ? w - 1'b1 - tx_c : tx_c;

	assign tall       = head.wall_height > {4'd0, cfg.screen_height};
	assign wh_excess  = head.wall_height - {4'd0, cfg.screen_height};
	assign start_prod = wh_excess * step_q;

	wcta_div #(
		.DW(DW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.busy    (div_busy),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcta_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		div_start   = 1'b0;
		div_dvd     = '0;
		div_dvs     = '0;
		head_pop    = 1'b0;
		emit        = 1'b0;
		frac_ld     = 1'b0;
		col_ld      = 1'b0;
		col_rem_ld  = 1'b0;
		step_ld     = 1'b0;
		acc_fast_ld = 1'b0;
		acc_rem_ld  = 1'b0;
		acc_clr     = 1'b0;
		fin_ld      = 1'b0;
		case (state_q)
			wcta_pkg::ST_IDLE: begin
				if (head_valid) begin
					if (head.func == wcta_pkg::FUNC_SETUP) begin
						state_d = wcta_pkg::ST_PROD;
					end else if (!active_q) begin
						head_pop = 1'b1;
					end else if (!acc_ok) begin
						div_start = 1'b1;
						div_dvd   = DW'(acc_q);
						div_dvs   = DW'(wrap);
						state_d   = wcta_pkg::ST_FIX_ACC;
					end else if (!col_ok) begin
						div_start = 1'b1;
						div_dvd   = DW'(col_q);
						div_dvs   = DW'(w);
						state_d   = wcta_pkg::ST_FIX_COL;
					end else if (out_free) begin
						emit = 1'b1;
						if (step_small) begin
							acc_fast_ld = 1'b1;
							head_pop    = 1'b1;
						end else begin
							div_start = 1'b1;
							div_dvd   = DW'(step_sum);
							div_dvs   = DW'(wrap);
							state_d   = wcta_pkg::ST_STEP_MOD;
						end
					end
				end
			end
			wcta_pkg::ST_PROD: begin
				frac_ld = 1'b1;
				state_d = wcta_pkg::ST_COL;
			end
			wcta_pkg::ST_COL: begin
				col_ld    = 1'b1;
				div_start = 1'b1;
				div_dvd   = DW'(wrap);
				div_dvs   = DW'(head.wall_height);
				state_d   = wcta_pkg::ST_DIV;
			end
			wcta_pkg::ST_DIV: begin
				if (div_done) begin
					step_ld = 1'b1;
					if (tall) begin
						state_d = wcta_pkg::ST_START;
					end else begin
						acc_clr  = 1'b1;
						fin_ld   = 1'b1;
						head_pop = 1'b1;
						state_d  = wcta_pkg::ST_IDLE;
					end
				end
			end
			wcta_pkg::ST_START: begin
				div_start = 1'b1;
				div_dvd   = start_prod >> 1;
				div_dvs   = DW'(wrap);
				state_d   = wcta_pkg::ST_SMOD;
			end
			wcta_pkg::ST_SMOD: begin
				if (div_done) begin
					acc_rem_ld = 1'b1;
					fin_ld     = 1'b1;
					head_pop   = 1'b1;
					state_d    = wcta_pkg::ST_IDLE;
				end
			end
			wcta_pkg::ST_FIX_ACC: begin
				if (div_done) begin
					acc_rem_ld = 1'b1;
					state_d    = wcta_pkg::ST_IDLE;
				end
			end
			wcta_pkg::ST_FIX_COL: begin
				if (div_done) begin
					col_rem_ld = 1'b1;
					state_d    = wcta_pkg::ST_IDLE;
				end
			end
			wcta_pkg::ST_STEP_MOD: begin
				if (div_done) begin
					acc_rem_ld = 1'b1;
					head_pop   = 1'b1;
					state_d    = wcta_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wcta_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			colm_q      <= '0;
			colw_q      <= '0;
			step_q      <= '0;
			acc_q       <= '0;
			cur_row_q   <= '0;
			end_row_q   <= '0;
			cur_col_q   <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (col_ld) begin
				col_q  <= tx_m[RW-1:0];
				colm_q <= tx_m[RW-1:0];
				colw_q <= w;
			end else if (col_rem_ld) begin
				colm_q <= div_rem[RW-1:0];
				colw_q <= w;
			end
			if (step_ld) begin
				step_q <= div_quo[SW-1:0];
			end
			if (acc_clr) begin
				acc_q <= '0;
			end else if (acc_rem_ld) begin
				acc_q <= div_rem[SW-1:0];
			end else if (acc_fast_ld) begin
				acc_q <= acc_next;
			end
			if (fin_ld) begin
				cur_row_q <= head.draw_start;
				end_row_q <= head.draw_end;
				cur_col_q <= head.column_x;
				active_q  <= head.draw_start < head.draw_end;
			end else if (emit) begin
				cur_row_q <= row_inc[11:0];
				if (pix_last) begin
					active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frac_ld) begin
			frac_q <= frac_sum[FW-1:0];
		end
		if (emit) begin
			out_col_q  <= cur_col_q;
			out_row_q  <= cur_row_q;
			out_off_q  <= off_full[25:0];
			out_last_q <= pix_last;
		end
	end

	assign empty        = !out_valid_q;
	assign out_column   = out_col_q;
	assign out_row      = out_row_q;
	assign texel_offset = out_off_q;
	assign last         = out_last_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && pix_last && !fin_ld) |=> !active_q)
		else $error("column still active after last pixel");

	a_fix_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wcta_pkg::ST_FIX_ACC && div_done) |=> (acc_q < $past(wrap)))
		else $error("row accumulator not reduced");

endmodule

### rtl/wall_column_texel_address_gen.sv
// ----------------------------------------------------------------------------
// wall_column_texel_address_gen
// Texture addressing for one ray-cast wall column: setup beats load the
// column, pixel beats of an active column return one texel byte offset each.
//
//   channel   direction  handshake               payload
//   input     in         push / full             func .. column_x
//   result    out        empty / pop             out_column .. last
//   config    in/out     psel penable pwrite     paddr pwdata prdata
//
// Pixel beats: one per clock once a column is loaded, while the result side
// takes them and no divide pass is needed; a result stall backs up the queue.
// Setup beats: one pass of the serial divider for the texture step, and a second
// pass for the start offset of walls taller than the screen.
// A pixel after a texture size change may take up to three extra divide passes.
// Reset: asynchronous, clears queue, column state and registers to defaults.
// ----------------------------------------------------------------------------
module wall_column_texel_address_gen #(
	parameter int FRAC_BITS   = 16,
	parameter int TEX_DIM_MAX = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic               side,
	input  logic [23:0]        pos_x,
	input  logic [23:0]        pos_y,
	input  logic [23:0]        perp_dist,
	input  logic signed [17:0] ray_dir_x,
	input  logic signed [17:0] ray_dir_y,
	input  logic [1:0]         view_dir_signs,
	input  logic [15:0]        wall_height,
	input  logic [11:0]        draw_start,
	input  logic [11:0]        draw_end,
	input  logic [11:0]        column_x,
	output logic               empty,
	input  logic               pop,
	output logic [11:0]        out_column,
	output logic [11:0]        out_row,
	output logic [25:0]        texel_offset,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	wcta_pkg::cfg_t  cfg_q;
	wcta_pkg::item_t in_item, head_item;
	logic            head_valid, head_pop, q_full, cfg_wr;
	logic [2:0]      reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign full    = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tex_width       <= wcta_pkg::RST_TEX_WIDTH;
			cfg_q.tex_height      <= wcta_pkg::RST_TEX_HEIGHT;
			cfg_q.screen_height   <= wcta_pkg::RST_SCREEN_HEIGHT;
			cfg_q.row_pitch       <= wcta_pkg::RST_ROW_PITCH;
			cfg_q.bytes_per_pixel <= wcta_pkg::RST_BYTES_PER_PIXEL;
		end else if (cfg_wr) begin
			case (reg_idx)
				wcta_pkg::REG_TEX_WIDTH:       cfg_q.tex_width       <= pwdata[10:0];
				wcta_pkg::REG_TEX_HEIGHT:      cfg_q.tex_height      <= pwdata[10:0];
				wcta_pkg::REG_SCREEN_HEIGHT:   cfg_q.screen_height   <= pwdata[11:0];
				wcta_pkg::REG_ROW_PITCH:       cfg_q.row_pitch       <= pwdata[15:0];
				wcta_pkg::REG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			wcta_pkg::REG_TEX_WIDTH:       prdata = 32'(cfg_q.tex_width);
			wcta_pkg::REG_TEX_HEIGHT:      prdata = 32'(cfg_q.tex_height);
			wcta_pkg::REG_SCREEN_HEIGHT:   prdata = 32'(cfg_q.screen_height);
			wcta_pkg::REG_ROW_PITCH:       prdata = 32'(cfg_q.row_pitch);
			wcta_pkg::REG_BYTES_PER_PIXEL: prdata = 32'(cfg_q.bytes_per_pixel);
			default:                       prdata = '0;
		endcase
	end

	wcta_front u_front (
		.func       (func),
		.side       (side),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.perp_dist  (perp_dist),
		.ray_dir_x  (ray_dir_x),
		.ray_dir_y  (ray_dir_y),
		.wall_height(wall_height),
		.draw_start (draw_start),
		.draw_end   (draw_end),
		.column_x   (column_x),
		.item       (in_item)
	);

	wcta_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !q_full),
		.wr_item (in_item),
		.full    (q_full),
		.rd_en   (head_pop),
		.rd_item (head_item),
		.rd_valid(head_valid)
	);

	wcta_back #(
		.FRAC_BITS  (FRAC_BITS),
		.TEX_DIM_MAX(TEX_DIM_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head_item),
		.head_valid  (head_valid),
		.head_pop    (head_pop),
		.pop         (pop && !empty),
		.empty       (empty),
		.out_column  (out_column),
		.out_row     (out_row),
		.texel_offset(texel_offset),
		.last        (last)
	);

endmodule

### bench/wall_column_texel_address_gen_test.sv
// ----------------------------------------------------------------------------
// wall_column_texel_address_gen_test
// Self-checking bench for the texel address generator. A directed table
// covers the reset defaults, field extremes, mirroring, tall walls, empty
// columns and column replacement. Random column setups followed by pixel
// streams then run under several register settings, the clamping extremes
// among them. Results are checked field by field against typed table values
// or an in-bench texel address predictor. Both sides idle at random.
// ----------------------------------------------------------------------------
module wall_column_texel_address_gen_test;

	localparam int FRAC = 16;
	localparam int DIM_MAX = 1024;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE = 250;
	localparam int PHASE_ITEMS = 135;

	typedef enum logic [1:0] {CHK_PRED, CHK_TYPED, CHK_NONE} chk_e;

	typedef struct {
		logic               func;
		logic               side;
		logic [23:0]        pos_x;
		logic [23:0]        pos_y;
		logic [23:0]        hit_dist;
		logic signed [17:0] rdx;
		logic signed [17:0] rdy;
		logic [1:0]         vds;
		logic [15:0]        wh;
		logic [11:0]        ds;
		logic [11:0]        de;
		logic [11:0]        col;
	} beat_t;

	typedef struct {
		logic [11:0] col;
		logic [11:0] row;
		logic [25:0] off;
		logic        last;
	} texel_t;

	typedef struct {
		beat_t  b;
		chk_e   chk;
		texel_t t;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic func = 1'b0;
	logic side = 1'b0;
	logic [23:0] pos_x = '0, pos_y = '0, perp_dist = '0;
	logic signed [17:0] ray_dir_x = '0, ray_dir_y = '0;
	logic [1:0] view_dir_signs = '0;
	logic [15:0] wall_height = '0;
	logic [11:0] draw_start = '0, draw_end = '0, column_x = '0;
	logic empty;
	logic pop = 1'b0;
	logic [11:0] out_column, out_row;
	logic [25:0] texel_offset;
	logic last;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	wall_column_texel_address_gen uut (.*);

	always #10 clk = ~clk;

	// register mirror and column state of the predictor
	wcta_pkg::cfg_t cfg;
	logic [9:0]  p_tex_col;
	logic [63:0] p_step, p_acc;
	logic [11:0] p_row, p_end, p_col;
	logic        p_active;

	row_t   stim_q[$];
	texel_t texel_due[$];
	beat_t  cur;
	chk_e   cur_chk;
	texel_t cur_typed;
	int errors = 0;
	int results_seen = 0;
	int burst_left = 8, gap_left = 0;
	logic rx_park = 1'b0;

	function automatic logic [10:0] clamp_dim(logic [10:0] v);
		if (v == 0) return 11'd1;
		if (v > DIM_MAX) return 11'(DIM_MAX);
		return v;
	endfunction

	task automatic texel_predict(input beat_t b, output logic have, output texel_t t);
		logic [63:0] w, h, wrap, base, frac, tx, whv, r, c;
		longint prod;
		w = 64'(clamp_dim(cfg.tex_width));
		h = 64'(clamp_dim(cfg.tex_height));
		wrap = h << FRAC;
		have = 1'b0;
		t = '{default: '0};
		if (b.func == wcta_pkg::FUNC_SETUP) begin
			base = b.side ? 64'(b.pos_x) : 64'(b.pos_y);
			prod = longint'(b.hit_dist) * (b.side ? longint'(b.rdx) : longint'(b.rdy));
			frac = ((base << FRAC) + 64'(prod)) & 64'hFFFF_FFFF;
			tx = (frac * w) >> (2 * FRAC);
			if (tx >= w) tx = w - 1;
			if ((!b.side && b.rdx > 0) || (b.side && b.rdy < 0)) tx = w - 1 - tx;
			p_tex_col = tx[9:0];
			whv = (b.wh == 0) ? 64'd1 : 64'(b.wh);
			p_step = (h << FRAC) / whv;
			p_acc = 0;
			if (whv > 64'(cfg.screen_height))
				p_acc = ((whv - 64'(cfg.screen_height)) * p_step) / 2;
			p_acc = p_acc % wrap;
			p_row = b.ds;
			p_end = b.de;
			p_col = b.col;
			p_active = b.ds < b.de;
		end else if (p_active) begin
			r = (p_acc >> FRAC) % h;
			c = 64'(p_tex_col) % w;
			have = 1'b1;
			t.col = p_col;
			t.row = p_row;
			t.off = 26'(r * 64'(cfg.row_pitch) + c * 64'(cfg.bytes_per_pixel));
			t.last = (13'(p_row) + 13'd1) >= 13'(p_end);
			p_acc = (p_acc + p_step) % wrap;
			p_row = p_row + 12'd1;
			if (t.last) p_active = 1'b0;
		end
	endtask

	// sender: bursts with random gaps
	always @(posedge clk) begin
		logic have;
		texel_t t;
		if (push && !full) begin
			texel_predict(cur, have, t);
			if (cur_chk == CHK_TYPED) texel_due.push_back(cur_typed);
			else if (cur_chk == CHK_PRED && have) texel_due.push_back(t);
		end
		if (!(push && full)) begin
			if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (stim_q.size() > 0) begin
				row_t nx;
				nx = stim_q.pop_front();
				cur = nx.b;
				cur_chk = nx.chk;
				cur_typed = nx.t;
				func <= nx.b.func;
				side <= nx.b.side;
				pos_x <= nx.b.pos_x;
				pos_y <= nx.b.pos_y;
				perp_dist <= nx.b.hit_dist;
				ray_dir_x <= nx.b.rdx;
				ray_dir_y <= nx.b.rdy;
				view_dir_signs <= nx.b.vds;
				wall_height <= nx.b.wh;
				draw_start <= nx.b.ds;
				draw_end <= nx.b.de;
				column_x <= nx.b.col;
				push <= 1'b1;
				if (--burst_left <= 0) begin
					burst_left = int'($urandom_range(1, 40));
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: stall pattern rotates through three modes
	always @(posedge clk) begin
		static int cyc = 0;
		texel_t e;
		if (pop && !empty) begin
			results_seen++;
			if (texel_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat col %h row %h off %h last %b", $time,
					out_column, out_row, texel_offset, last);
			end else begin
				e = texel_due.pop_front();
				if (out_column !== e.col || out_row !== e.row ||
					texel_offset !== e.off || last !== e.last) begin
					errors++;
					$display("%0t: mismatch expected col %h row %h off %h last %b",
						$time, e.col, e.row, e.off, e.last);
					$display("%0t:          actual   col %h row %h off %h last %b",
						$time, out_column, out_row, texel_offset, last);
				end
			end
		end
		cyc++;
		case ((cyc / 64) % 3)
			0: pop <= !rx_park;
			1: pop <= !rx_park && ($urandom_range(0, 1) == 1);
			default: pop <= !rx_park && ($urandom_range(0, 4) != 0);
		endcase
	end

	// long hold-off while the sender still has beats, so the block fills up
	initial begin
		wait (results_seen > 20 && stim_q.size() > 60);
		@(posedge clk) rx_park <= 1'b1;
		repeat (400) @(posedge clk);
		rx_park <= 1'b0;
	end

	always @(posedge clk) begin
		static int idle = 0;
		if ((push && !full) || (pop && !empty) || psel) idle = 0;
		else idle++;
		if (idle >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk) penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			wcta_pkg::REG_TEX_WIDTH: cfg.tex_width = v[10:0];
			wcta_pkg::REG_TEX_HEIGHT: cfg.tex_height = v[10:0];
			wcta_pkg::REG_SCREEN_HEIGHT: cfg.screen_height = v[11:0];
			wcta_pkg::REG_ROW_PITCH: cfg.row_pitch = v[15:0];
			default: cfg.bytes_per_pixel = v[3:0];
		endcase
	endtask

	task automatic drain;
		wait (stim_q.size() == 0 && !push && texel_due.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic beat_t rand_beat(logic f);
		beat_t b;
		b.func = f;
		b.side = 1'($urandom_range(0, 1));
		b.pos_x = 24'($urandom);
		b.pos_y = 24'($urandom);
		b.hit_dist = ($urandom_range(0, 3) == 0) ? 24'($urandom) :
			24'($urandom_range(0, 24'h0FFFFF));
		b.rdx = 18'($urandom);
		b.rdy = 18'($urandom);
		b.vds = 2'($urandom);
		b.wh = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1200));
		b.ds = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 600));
		b.de = ($urandom_range(0, 9) == 0) ? 12'($urandom) :
			b.ds + 12'($urandom_range(0, ($urandom_range(0, 19) == 0) ? 120 : 20));
		b.col = 12'($urandom);
		return b;
	endfunction

	task automatic add_row(input beat_t b, input chk_e k, input texel_t t);
		row_t r;
		r.b = b;
		r.chk = k;
		r.t = t;
		stim_q.push_back(r);
	endtask

	task automatic random_phase(input int n);
		beat_t b;
		texel_t z;
		int k, px;
		z = '{default: '0};
		k = 0;
		while (k < n) begin
			b = rand_beat(wcta_pkg::FUNC_SETUP);
			add_row(b, CHK_PRED, z);
			k++;
			px = (b.ds < b.de) ? int'(b.de - b.ds) : 0;
			if ($urandom_range(0, 5) == 0) px = int'($urandom_range(0, px));
			else px += int'($urandom_range(0, 2));
			repeat (px) begin
				add_row(rand_beat(wcta_pkg::FUNC_PIXEL), CHK_PRED, z);
				k++;
			end
		end
	endtask

	initial begin
		beat_t zb, b;
		texel_t z;
		row_t dir_tab[$];
		logic [31:0] phase_cfg[6][5];
		cfg = '{wcta_pkg::RST_TEX_WIDTH, wcta_pkg::RST_TEX_HEIGHT,
			wcta_pkg::RST_SCREEN_HEIGHT, wcta_pkg::RST_ROW_PITCH,
			wcta_pkg::RST_BYTES_PER_PIXEL};
		{p_tex_col, p_step, p_acc, p_row, p_end, p_col, p_active} = '0;
		z = '{default: '0};
		zb = '{func: wcta_pkg::FUNC_SETUP, side: 1'b0, pos_x: 0, pos_y: 0, hit_dist: 0,
			rdx: 0, rdy: 0, vds: 0, wh: 16'd64, ds: 0, de: 12'd2, col: 12'd5};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		dir_tab.push_back('{zb, CHK_PRED, z});
		b = zb; b.func = wcta_pkg::FUNC_PIXEL;
		dir_tab.push_back('{b, CHK_TYPED, '{12'd5, 12'd0, 26'd0, 1'b0}});
		dir_tab.push_back('{b, CHK_TYPED, '{12'd5, 12'd1, 26'd256, 1'b1}});
		dir_tab.push_back('{b, CHK_NONE, z});
		b = '{wcta_pkg::FUNC_SETUP, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 18'sh1FFFF,
			18'sh1FFFF, 2'd3, 16'hFFFF, 12'd4094, 12'd4095, 12'hFFF};
		dir_tab.push_back('{b, CHK_PRED, z});
		b.func = wcta_pkg::FUNC_PIXEL;
		dir_tab.push_back('{b, CHK_PRED, z});
		dir_tab.push_back('{b, CHK_NONE, z});
		b = '{wcta_pkg::FUNC_SETUP, 1'b0, 24'h0, 24'h123456, 24'hFFFFFF, -18'sd131072,
			-18'sd131072, 2'd0, 16'd0, 12'd10, 12'd5, 12'd1};
		dir_tab.push_back('{b, CHK_PRED, z});
		b.func = wcta_pkg::FUNC_PIXEL;
		dir_tab.push_back('{b, CHK_NONE, z});
		b = '{wcta_pkg::FUNC_SETUP, 1'b0, 24'h0, 24'h018000, 24'h010000, 18'sd1000,
			18'sd20000, 2'd1, 16'd1000, 12'd0, 12'd3, 12'd2};
		dir_tab.push_back('{b, CHK_PRED, z});
		b.func = wcta_pkg::FUNC_PIXEL;
		repeat (3) dir_tab.push_back('{b, CHK_PRED, z});
		b = '{wcta_pkg::FUNC_SETUP, 1'b1, 24'h024000, 24'h0, 24'h020000, 18'sd5000,
			-18'sd9000, 2'd2, 16'd200, 12'd100, 12'd104, 12'd7};
		dir_tab.push_back('{b, CHK_PRED, z});
		b.func = wcta_pkg::FUNC_PIXEL;
		dir_tab.push_back('{b, CHK_PRED, z});
		b = '{wcta_pkg::FUNC_SETUP, 1'b0, 24'h0, 24'h0, 24'h0, 18'sd0, 18'sd0, 2'd0, 16'd1,
			12'd0, 12'd1, 12'd9};
		dir_tab.push_back('{b, CHK_PRED, z});
		b.func = wcta_pkg::FUNC_PIXEL;
		dir_tab.push_back('{b, CHK_PRED, z});
		dir_tab.push_back('{b, CHK_NONE, z});
		foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);

		random_phase(PHASE_ITEMS);
		drain();

		phase_cfg = '{'{1, 1, 1, 1, 1}, '{1024, 1024, 4095, 65535, 8},
			'{0, 0, 0, 0, 0}, '{2047, 2047, 4095, 65535, 15},
			'{$urandom_range(1, 1024), $urandom_range(1, 1024), $urandom_range(1, 4095),
				$urandom_range(1, 65535), $urandom_range(1, 8)},
			'{37, 100, 240, 4096, 3}};
		foreach (phase_cfg[p]) begin
			reg_write(wcta_pkg::REG_TEX_WIDTH, phase_cfg[p][0]);
			reg_write(wcta_pkg::REG_TEX_HEIGHT, phase_cfg[p][1]);
			reg_write(wcta_pkg::REG_SCREEN_HEIGHT, phase_cfg[p][2]);
			reg_write(wcta_pkg::REG_ROW_PITCH, phase_cfg[p][3]);
			reg_write(wcta_pkg::REG_BYTES_PER_PIXEL, phase_cfg[p][4]);
			random_phase(PHASE_ITEMS - 25 * (p == 5));
			drain();
		end

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
